FILE: hw/rtl/msip_pkg.sv
// shared types and constants of the motion sleep interval policy
`default_nettype none
package msip_pkg;

	// register map, one 64-bit register every 8 bytes
	localparam int unsigned ADDR_W   = 6;
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STOP_THRESHOLD = 3'd0,
		REG_PAUSE_SECONDS  = 3'd1,
		REG_MIN_SPEED      = 3'd2,
		REG_GAP_LIMIT      = 3'd3,
		REG_ENTRY_A        = 3'd4,
		REG_ENTRY_B        = 3'd5,
		REG_ENTRY_C        = 3'd6,
		REG_ENTRY_D        = 3'd7
	} reg_idx_t;

	// reset values of the configuration registers and of the slow-fix count
	localparam logic [7:0]  RST_STOP_THRESHOLD = 8'd5;
	localparam logic [15:0] RST_PAUSE_SECONDS  = 16'd300;
	localparam logic [7:0]  RST_MIN_SPEED      = 8'd5;
	localparam logic [15:0] RST_GAP_LIMIT      = 16'd3000;
	localparam logic [7:0]  RST_SLOW_COUNT     = 8'd4;

	// widths of the stream items
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 32;

	// motion state codes reported with each result
	typedef enum logic [2:0] {
		ST_MOVING     = 3'd0,
		ST_PAUSED     = 3'd1,
		ST_ABOUT_STOP = 3'd2,
		ST_STOPPED    = 3'd3,
		ST_STATIC     = 3'd4
	} motion_state_t;

	// one timing table entry, packed as in its register
	typedef struct packed {
		logic        valid;
		logic [7:0]  speed;
		logic [10:0] tmin;
		logic [10:0] tmax;
		logic [15:0] seconds;
	} entry_t;

	// scalar policy settings
	typedef struct packed {
		logic [7:0]  stop_threshold;
		logic [15:0] pause_seconds;
		logic [7:0]  min_moving_speed;
		logic [15:0] gap_limit_m;
	} policy_cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/motion_sleep_interval_policy.sv
// top level: fix stream in, sleep interval stream out, apb configuration
//
// Usage:
//   s_axis carries one position fix per item (speed, minute of day, gap
//   distance in tdata, time-valid flag in tuser). m_axis returns one result
//   per fix (sleep interval, motion state, slow-fix count in tdata, table hit
//   flag in tuser), in the same order.
//   An accepted fix lands in an input register; the table compare and
//   slow-fix counter update then run, and the result register loads when
//   it is empty or its result is being taken. Throughput is one fix per
//   cycle while m_axis_tready stays high: the slow-fix counter is updated
//   in the same cycle that its result register loads, so consecutive fixes
//   chain without bubbles. When the receiver holds m_axis_tready low, the
//   result stays in place and the input register still takes one more fix;
//   s_axis_tready falls only when both are full. Reset clears both stages,
//   loads the register reset values and sets the slow-fix count to four.
//   Configuration is written through the apb port (64-bit registers at
//   8-byte steps); the user must write it only while no fix is in flight,
//   which the block itself does not enforce.
`default_nettype none
module motion_sleep_interval_policy #(
	parameter int unsigned TIMING_ENTRIES = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// fix items
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [7:0] speed_kmh, [18:8] minute_of_day, [34:19] gap_distance_m, rest zero
	input  wire logic [msip_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [0] time_valid
	input  wire logic                                s_axis_tuser,
	// result items
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [15:0] sleep_seconds, [18:16] motion_state, [26:19] stop_count, rest zero
	output logic      [msip_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [0] table_hit
	output logic                                     m_axis_tuser,
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [msip_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [msip_pkg::DATA_W-1:0]         pwdata,
	output logic      [msip_pkg::DATA_W-1:0]         prdata,
	output logic                                     pready
);

	msip_pkg::policy_cfg_t                 cfg;
	msip_pkg::entry_t [TIMING_ENTRIES-1:0] entries;

	logic        valid_s1;
	logic [7:0]  speed_s1;
	logic        tvalid_s1;
	logic [10:0] minute_s1;
	logic [15:0] gap_s1;
	logic        advance;
	logic        in_take;

	logic [7:0]  count_q;
	logic        out_valid_q;
	logic [15:0] out_secs_q;
	msip_pkg::motion_state_t out_state_q;
	logic        out_hit_q;

	logic        hit;
	logic [15:0] table_secs;
	logic        slow;
	logic [8:0]  inc_cnt;
	logic [8:0]  thr_plus1;
	logic [8:0]  sat_cnt;
	logic [7:0]  count_next;
	logic [15:0] secs_next;
	msip_pkg::motion_state_t state_next;

	msip_cfg_regs #(
		.TIMING_ENTRIES(TIMING_ENTRIES)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.entries(entries)
	);

	// handshake between the two stages
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			speed_s1  <= s_axis_tdata[7:0];
			minute_s1 <= s_axis_tdata[18:8];
			gap_s1    <= s_axis_tdata[34:19];
			tvalid_s1 <= s_axis_tuser;
		end
	end

	msip_table_match #(
		.TIMING_ENTRIES(TIMING_ENTRIES)
	) u_match (
		.entries      (entries),
		.speed_kmh    (speed_s1),
		.time_valid   (tvalid_s1),
		.minute_of_day(minute_s1),
		.hit          (hit),
		.seconds      (table_secs)
	);

	// slow-fix count, saturating at threshold plus one
	assign slow      = speed_s1 < cfg.min_moving_speed;
	assign inc_cnt   = {1'b0, count_q} + 9'd1;
	assign thr_plus1 = {1'b0, cfg.stop_threshold} + 9'd1;
	assign sat_cnt   = (inc_cnt > thr_plus1) ? thr_plus1 : inc_cnt;

	always_comb begin
		if (!slow || (gap_s1 > cfg.gap_limit_m)) begin
			count_next = '0;
		end else if (sat_cnt[8]) begin
			count_next = 8'hFF;
		end else begin
			count_next = sat_cnt[7:0];
		end
	end

	// state and interval selection
	always_comb begin
		secs_next  = table_secs;
		state_next = msip_pkg::ST_MOVING;
		if (slow) begin
			if (count_next < cfg.stop_threshold) begin
				secs_next  = cfg.pause_seconds;
				state_next = (count_next == cfg.stop_threshold - 8'd1) ?
				             msip_pkg::ST_ABOUT_STOP : msip_pkg::ST_PAUSED;
			end else if (count_next == cfg.stop_threshold) begin
				state_next = msip_pkg::ST_STOPPED;
			end else begin
				state_next = msip_pkg::ST_STATIC;
			end
		end
	end

	// counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= msip_pkg::RST_SLOW_COUNT;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			count_q     <= count_next;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_secs_q  <= secs_next;
			out_state_q <= state_next;
			out_hit_q   <= hit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, count_q, out_state_q, out_secs_q};
	assign m_axis_tuser  = out_hit_q;

endmodule
`default_nettype wire

FILE: hw/rtl/msip_cfg_regs.sv
// configuration register file behind the apb port
`default_nettype none
module msip_cfg_regs #(
	parameter int unsigned TIMING_ENTRIES = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [msip_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [msip_pkg::DATA_W-1:0]      pwdata,
	output logic      [msip_pkg::DATA_W-1:0]      prdata,
	output logic                                  pready,
	output msip_pkg::policy_cfg_t                 cfg,
	output msip_pkg::entry_t [TIMING_ENTRIES-1:0] entries
);

	logic                           wr_en;
	logic [msip_pkg::REG_IDX_W-1:0] idx;
	msip_pkg::policy_cfg_t          cfg_q;
	msip_pkg::entry_t [TIMING_ENTRIES-1:0] entry_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[msip_pkg::ADDR_W-1:msip_pkg::ADDR_W-msip_pkg::REG_IDX_W];

	// scalar registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_threshold   <= msip_pkg::RST_STOP_THRESHOLD;
			cfg_q.pause_seconds    <= msip_pkg::RST_PAUSE_SECONDS;
			cfg_q.min_moving_speed <= msip_pkg::RST_MIN_SPEED;
			cfg_q.gap_limit_m      <= msip_pkg::RST_GAP_LIMIT;
		end else if (wr_en) begin
			case (idx)
				msip_pkg::REG_STOP_THRESHOLD: cfg_q.stop_threshold   <= pwdata[7:0];
				msip_pkg::REG_PAUSE_SECONDS:  cfg_q.pause_seconds    <= pwdata[15:0];
				msip_pkg::REG_MIN_SPEED:      cfg_q.min_moving_speed <= pwdata[7:0];
				msip_pkg::REG_GAP_LIMIT:      cfg_q.gap_limit_m      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// timing table registers, one per entry
	for (genvar g = 0; g < TIMING_ENTRIES; g++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				entry_q[g] <= '0;
			end else if (wr_en &&
			             idx == msip_pkg::REG_IDX_W'(msip_pkg::REG_ENTRY_A + g)) begin
				entry_q[g] <= pwdata[$bits(msip_pkg::entry_t)-1:0];
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		case (idx)
			msip_pkg::REG_STOP_THRESHOLD:
				prdata = msip_pkg::DATA_W'(cfg_q.stop_threshold);
			msip_pkg::REG_PAUSE_SECONDS:
				prdata = msip_pkg::DATA_W'(cfg_q.pause_seconds);
			msip_pkg::REG_MIN_SPEED:
				prdata = msip_pkg::DATA_W'(cfg_q.min_moving_speed);
			msip_pkg::REG_GAP_LIMIT:
				prdata = msip_pkg::DATA_W'(cfg_q.gap_limit_m);
			default: begin
				for (int i = 0; i < TIMING_ENTRIES; i++) begin
					if (idx == msip_pkg::REG_IDX_W'(msip_pkg::REG_ENTRY_A + i)) begin
						prdata = msip_pkg::DATA_W'(entry_q[i]);
					end
				end
			end
		endcase
	end

	assign cfg     = cfg_q;
	assign entries = entry_q;

endmodule
`default_nettype wire

FILE: hw/rtl/msip_table_match.sv
// parallel compare of one fix against the timing table, highest entry wins
`default_nettype none
module msip_table_match #(
	parameter int unsigned TIMING_ENTRIES = 4
) (
	input  wire msip_pkg::entry_t [TIMING_ENTRIES-1:0] entries,
	input  wire logic [7:0]                       speed_kmh,
	input  wire logic                             time_valid,
	input  wire logic [10:0]                      minute_of_day,
	output logic                                  hit,
	output logic [15:0]                           seconds
);

	logic [TIMING_ENTRIES-1:0] match;

	// per entry match
	always_comb begin
		for (int i = 0; i < TIMING_ENTRIES; i++) begin
			match[i] = entries[i].valid && (speed_kmh >= entries[i].speed) &&
			           (!time_valid || ((minute_of_day >= entries[i].tmin) &&
			                            (minute_of_day <= entries[i].tmax)));
		end
	end

	// priority select, later entries override earlier ones
	always_comb begin
		hit     = 1'b0;
		seconds = '0;
		for (int i = 0; i < TIMING_ENTRIES; i++) begin
			if (match[i]) begin
				hit     = 1'b1;
				seconds = entries[i].seconds;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/msip_checker.sv
// port-level checks on the result stream of the policy block
`default_nettype none
module msip_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                m_axis_tvalid,
	input wire logic                                m_axis_tready,
	input wire logic [msip_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input wire logic                                m_axis_tuser
);

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// state code stays within the defined codes
	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[18:16] <= msip_pkg::ST_STATIC)
		else $error("undefined motion state");

	// moving always clears the slow-fix count
	a_moving_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[18:16] == msip_pkg::ST_MOVING
		|-> m_axis_tdata[26:19] == 8'd0)
		else $error("moving with non-zero count");

	// a table miss gives zero where the table result is used
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser &&
		(m_axis_tdata[18:16] == msip_pkg::ST_MOVING ||
		 m_axis_tdata[18:16] == msip_pkg::ST_STOPPED ||
		 m_axis_tdata[18:16] == msip_pkg::ST_STATIC)
		|-> m_axis_tdata[15:0] == 16'd0)
		else $error("non-zero interval on table miss");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0)
		else $error("padding bits set");

endmodule

bind motion_sleep_interval_policy msip_checker u_msip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
